// ===== design/qtll_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qtll_pkg
// Shared types and fixed constants of the quantile table lookup block:
// controller states, controller-to-datapath commands and datapath status.
// ----------------------------------------------------------------------------
package qtll_pkg;

  localparam int SAMPLE_W   = 32;  // in_sample width, Q16.16
  localparam int INDEX_W    = 7;   // in_entry_index width
  localparam int RANK_W     = 17;  // out_rank width, Q0.16 with 1.0 included
  localparam int FRAC_W     = 17;  // interpolation fraction, 0..65536
  localparam int FRAC_CNT_W = 5;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic [RANK_W-1:0]     ONE_Q16   = 17'd65536;
  localparam logic [FRAC_CNT_W-1:0] FRAC_LAST = 5'd16;  // 17 restoring steps

  // 10.0 in Q16.16, the span of the table after reset
  localparam int RESET_SPAN = 655360;
  localparam int RSPAN_W    = 20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_FETCH,
    ST_COMPARE,
    ST_FRAC,
    ST_PREP,
    ST_SCALE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;        // capture the item, restart the scan
    logic wr_entry;    // store the table entry
    logic advance;     // move the scan to the next entry
    logic rank_zero;
    logic rank_full;
    logic frac_init;
    logic frac_step;
    logic scale_init;
    logic scale_step;
  } cmd_t;

  typedef struct packed {
    logic lookup;      // item on the input ports is a lookup
    logic hit;         // current entry is at or above the sample
    logic first;       // scan is at entry 0
    logic last;        // scan is at the last entry
    logic frac_done;
  } sts_t;

endpackage
`default_nettype wire

// ===== design/qtll_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qtll_ctrl
// Sequencer of the quantile lookup: write path, linear table scan, then the
// fraction division and the rank scaling.
// ----------------------------------------------------------------------------
module qtll_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  output logic                out_strobe,
  output qtll_pkg::cmd_t      cmd,
  input  wire qtll_pkg::sts_t sts
);

  qtll_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qtll_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qtll_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = sts.lookup ? qtll_pkg::ST_FETCH : qtll_pkg::ST_WRITE;
        end
      end
      qtll_pkg::ST_WRITE:   state_nxt = qtll_pkg::ST_DONE;
      qtll_pkg::ST_FETCH:   state_nxt = qtll_pkg::ST_COMPARE;
      qtll_pkg::ST_COMPARE: begin
        priority if (sts.hit) begin
          state_nxt = sts.first ? qtll_pkg::ST_DONE : qtll_pkg::ST_FRAC;
        end else if (sts.last) begin
          state_nxt = qtll_pkg::ST_DONE;
        end else begin
          state_nxt = qtll_pkg::ST_FETCH;
        end
      end
      qtll_pkg::ST_FRAC: begin
        if (sts.frac_done) begin
          state_nxt = qtll_pkg::ST_PREP;
        end
      end
      qtll_pkg::ST_PREP:  state_nxt = qtll_pkg::ST_SCALE;
      qtll_pkg::ST_SCALE: state_nxt = qtll_pkg::ST_DONE;
      qtll_pkg::ST_DONE:  state_nxt = qtll_pkg::ST_IDLE;
      default:            state_nxt = qtll_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    busy       = (state_r != qtll_pkg::ST_IDLE);
    out_strobe = (state_r == qtll_pkg::ST_DONE);
    unique case (state_r)
      qtll_pkg::ST_IDLE:    cmd.load     = start;
      qtll_pkg::ST_WRITE:   cmd.wr_entry = 1'b1;
      qtll_pkg::ST_COMPARE: begin
        priority if (sts.hit) begin
          cmd.rank_zero = sts.first;
          cmd.frac_init = !sts.first;
        end else if (sts.last) begin
          cmd.rank_full = 1'b1;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      qtll_pkg::ST_FRAC:    cmd.frac_step  = 1'b1;
      qtll_pkg::ST_PREP:    cmd.scale_init = 1'b1;
      qtll_pkg::ST_SCALE:   cmd.scale_step = 1'b1;
      default:              cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/qtll_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qtll_dp
// Datapath: quantile table memory with per-entry valid bits, scan registers,
// restoring divider for the segment fraction and a reciprocal multiply for
// the division by the table size.
// ----------------------------------------------------------------------------
module qtll_dp #(
  parameter int TABLE_ENTRIES = 100,
  parameter int VALUE_BITS    = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire qtll_pkg::cmd_t                    cmd,
  output qtll_pkg::sts_t                         sts,
  input  wire logic                              in_kind,
  input  wire logic [qtll_pkg::INDEX_W-1:0]      in_entry_index,
  input  wire logic [qtll_pkg::SAMPLE_W-1:0]     in_sample,
  output logic [qtll_pkg::RANK_W-1:0]            out_rank
);

  localparam int IW     = $clog2(TABLE_ENTRIES);
  localparam int SW     = IW + 1;
  localparam int XW     = IW + 16;
  localparam int RSH    = XW + IW;
  localparam int MW     = XW + 1;
  localparam int PW     = XW + MW;
  localparam int STEP_A = qtll_pkg::RESET_SPAN / TABLE_ENTRIES;
  localparam int STEP_B = qtll_pkg::RESET_SPAN % TABLE_ENTRIES;
  localparam int VB     = VALUE_BITS;

  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
  localparam logic [SW-1:0] N_SW     = SW'(TABLE_ENTRIES);
  // ceil(2^RSH / TABLE_ENTRIES): floor division stays exact for any XW-bit dividend
  localparam logic [MW-1:0] RECIP    =
    MW'(((64'd1 << RSH) + 64'(TABLE_ENTRIES - 1)) / 64'(TABLE_ENTRIES));

  logic [VB-1:0] mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld_r;

  logic [qtll_pkg::INDEX_W-1:0] ent_r;
  logic [VB-1:0]                v_r, prev_r, rd_r, den_r;
  logic                         rdv_r;
  logic [IW-1:0]                idx_r, d_r;
  logic [qtll_pkg::RSPAN_W-1:0] rq_r;
  logic [SW-1:0]                rr_r, rr_sum;
  logic [VB:0]                  fr_r, fr_nxt, ftrial;
  logic [qtll_pkg::FRAC_W-1:0]  fq_r, fq_nxt;
  logic [qtll_pkg::FRAC_CNT_W-1:0] fc_r;
  logic                         fge;
  logic [XW-1:0]                sx_r;
  logic [PW-1:0]                sprod;
  logic [qtll_pkg::RANK_W-1:0]  rank_r;

  logic [VB-1:0] ent_val;
  logic          wr_ok;
  logic [IW-1:0] wr_addr;

  // an entry never written reads as its reset value, tracked along the scan
  assign ent_val = rdv_r ? rd_r : VB'(rq_r);
  assign wr_ok   = (int'(ent_r) < TABLE_ENTRIES);
  assign wr_addr = IW'(ent_r);
  assign rr_sum  = rr_r + SW'(STEP_B);

  assign ftrial = (fc_r == '0) ? fr_r : {fr_r[VB-1:0], 1'b0};
  assign fge    = (ftrial >= {1'b0, den_r});
  assign fr_nxt = fge ? (ftrial - {1'b0, den_r}) : ftrial;
  assign fq_nxt = {fq_r[qtll_pkg::FRAC_W-2:0], fge};

  assign sprod = PW'(sx_r) * PW'(RECIP);

  always_comb begin
    sts.lookup     = (in_kind == qtll_pkg::KIND_LOOKUP);
    sts.hit        = (ent_val >= v_r);
    sts.first      = (idx_r == '0);
    sts.last       = (idx_r == LAST_IDX);
    sts.frac_done  = (fc_r == qtll_pkg::FRAC_LAST);
  end

  assign out_rank = rank_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_entry && wr_ok) begin
      mem[wr_addr] <= v_r;
    end
    rd_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.wr_entry && wr_ok) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rdv_r <= vld_r[idx_r];

    if (cmd.load) begin
      ent_r <= in_entry_index;
      v_r   <= VB'(in_sample);
      idx_r <= '0;
      rq_r  <= '0;
      rr_r  <= '0;
    end

    if (cmd.advance) begin
      idx_r  <= idx_r + IW'(1);
      prev_r <= ent_val;
      if (rr_sum >= N_SW) begin
        rr_r <= rr_sum - N_SW;
        rq_r <= rq_r + qtll_pkg::RSPAN_W'(STEP_A + 1);
      end else begin
        rr_r <= rr_sum;
        rq_r <= rq_r + qtll_pkg::RSPAN_W'(STEP_A);
      end
    end

    if (cmd.wr_entry || cmd.rank_zero) begin
      rank_r <= '0;
    end
    if (cmd.rank_full) begin
      rank_r <= qtll_pkg::ONE_Q16;
    end

    // lo < v <= hi, so the divisor is never zero
    if (cmd.frac_init) begin
      den_r <= ent_val - prev_r;
      fr_r  <= {1'b0, v_r - prev_r};
      fq_r  <= '0;
      fc_r  <= '0;
      d_r   <= idx_r;
    end
    if (cmd.frac_step) begin
      fr_r <= fr_nxt;
      fq_r <= fq_nxt;
      fc_r <= fc_r + qtll_pkg::FRAC_CNT_W'(1);
    end

    if (cmd.scale_init) begin
      sx_r <= {d_r - IW'(1), 16'b0} + XW'(fq_r);
    end
    // quotient by the table size sits above the RSH fraction bits
    if (cmd.scale_step) begin
      rank_r <= sprod[RSH +: qtll_pkg::RANK_W];
    end
  end

endmodule
`default_nettype wire

// ===== design/quantile_table_lookup_lerp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quantile_table_lookup_lerp
// Maps a Q16.16 sample to its normalised rank (Q0.16) through a table of
// quantile values, interpolating inside the bracketing segment.
// ----------------------------------------------------------------------------
// Usage: one item at a time; start is taken when busy is low. A write item
// passes through the WRITE state, then gives its strobe (rank 0). A lookup
// walks the table from entry 0 through the table memory, fetching each entry
// and comparing it in turn, until it finds the first entry at or above the
// sample (d). At entry 0 or past the end the strobe comes in the next cycle;
// otherwise a 17-step restoring divider forms the segment fraction, the PREP
// state loads the scaled dividend and one multiply by the reciprocal of
// TABLE_ENTRIES gives the rank. busy drops after the strobe cycle, so the
// next transfer can come in the cycle after the strobe. The result is on
// out_rank for the single cycle that out_strobe is high and must be taken
// then. After reset the table holds 10*i/TABLE_ENTRIES.
// ----------------------------------------------------------------------------
module quantile_table_lookup_lerp #(
  parameter int TABLE_ENTRIES = 100,
  parameter int VALUE_BITS    = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_kind,
  input  wire logic [qtll_pkg::INDEX_W-1:0]  in_entry_index,
  input  wire logic [qtll_pkg::SAMPLE_W-1:0] in_sample,
  output logic                               out_strobe,
  output logic [qtll_pkg::RANK_W-1:0]        out_rank
);

  qtll_pkg::cmd_t cmd;
  qtll_pkg::sts_t sts;

  qtll_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd),
    .sts        (sts)
  );

  qtll_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .VALUE_BITS    (VALUE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (in_kind),
    .in_entry_index (in_entry_index),
    .in_sample      (in_sample),
    .out_rank       (out_rank)
  );

endmodule
`default_nettype wire

// ===== design/qtll_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qtll_checker
// Port-level checks of the quantile lookup block, bound to the top level.
// ----------------------------------------------------------------------------
module qtll_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          in_kind,
  input wire logic                          out_strobe,
  input wire logic [qtll_pkg::RANK_W-1:0]   out_rank
);

  // a result is shown for one cycle only
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("out_strobe held for more than one cycle");

  // results appear only while an item is in flight
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("out_strobe without busy");

  a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_rank <= qtll_pkg::ONE_Q16))
    else $error("out_rank above 1.0");

  // a write item answers with rank zero after its transfer and the WRITE state
  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_kind == qtll_pkg::KIND_WRITE))
      |-> ##2 (out_strobe && (out_rank == '0)))
    else $error("write item did not return rank zero on time");

endmodule

bind quantile_table_lookup_lerp qtll_checker u_qtll_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_kind    (in_kind),
  .out_strobe (out_strobe),
  .out_rank   (out_rank)
);
`default_nettype wire

// ===== tb/tb_quantile_table_lookup_lerp.sv =====
// ----------------------------------------------------------------------------
// tb_quantile_table_lookup_lerp
// Self-checking bench for the quantile table lookup block. A mirror of the
// table and a rank predictor follow every accepted transfer. Each strobed rank
// is compared with the oldest predicted one. The stimulus runs in this order:
// directed lookups against the reset table, edge and out-of-range writes,
// then random traffic. The random traffic rebuilds sorted tables, pokes
// single entries and sends lookups, in three phases of sender idling.
// ----------------------------------------------------------------------------
module tb_quantile_table_lookup_lerp;

  localparam int          TBL_N        = 100;
  localparam int          RESET_CYCLES = 6;
  localparam int          DRAIN_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;

  typedef struct {
    int unsigned                 seq;
    logic [qtll_pkg::RANK_W-1:0] rank;
  } due_rank_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic                          in_kind;
  logic [qtll_pkg::INDEX_W-1:0]  in_entry_index;
  logic [qtll_pkg::SAMPLE_W-1:0] in_sample;
  logic                          out_strobe;
  logic [qtll_pkg::RANK_W-1:0]   out_rank;

  logic [qtll_pkg::SAMPLE_W-1:0] quantile_mirror [TBL_N];
  due_rank_t                     pending_ranks [$];
  due_rank_t                     due;

  int unsigned sender_idle_pct;
  int unsigned n_transfers;
  int unsigned n_writes;
  int unsigned n_dropped_writes;
  int unsigned n_lookups;
  int unsigned n_checked;
  int unsigned n_mismatch;
  int unsigned cycle_count = 0;

  quantile_table_lookup_lerp #(
    .TABLE_ENTRIES (TBL_N),
    .VALUE_BITS    (qtll_pkg::SAMPLE_W)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_entry_index (in_entry_index),
    .in_sample      (in_sample),
    .out_strobe     (out_strobe),
    .out_rank       (out_rank)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d ranks outstanding", cycle_count,
               pending_ranks.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    n_mismatch++;
    $display("[cycle %0d] mismatch: %s", cycle_count, msg);
  endtask

  // First entry at or above the sample, then interpolate inside the
  // segment that brackets it.
  function automatic logic [qtll_pkg::RANK_W-1:0] predict_rank(
      input logic [qtll_pkg::SAMPLE_W-1:0] v);
    int unsigned d;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] frac;
    d = 0;
    while (d < TBL_N && quantile_mirror[d] < v)
      d++;
    if (d == TBL_N)
      return qtll_pkg::ONE_Q16;
    if (d == 0)
      return '0;
    lo   = 64'(quantile_mirror[d-1]);
    hi   = 64'(quantile_mirror[d]);
    frac = ((64'(v) - lo) << 16) / (hi - lo);
    return qtll_pkg::RANK_W'((64'(d - 1) * 64'd65536 + frac) / TBL_N);
  endfunction

  // Hold the item until the block takes it; start may drop at random meanwhile.
  // busy is looked at mid-cycle, where it already shows its value at the next edge.
  task automatic issue_item(input logic kind, input logic [qtll_pkg::INDEX_W-1:0] idx,
                            input logic [qtll_pkg::SAMPLE_W-1:0] sample);
    bit        drive;
    bit        taken;
    due_rank_t item;
    taken          = 1'b0;
    in_kind        <= kind;
    in_entry_index <= idx;
    in_sample      <= sample;
    while (!taken) begin
      drive = ($urandom_range(99) >= sender_idle_pct);
      start <= drive;
      @(negedge clk);
      taken = drive && (busy === 1'b0);
      @(posedge clk);
    end
    item.seq = n_transfers;
    n_transfers++;
    if (kind == qtll_pkg::KIND_WRITE) begin
      item.rank = '0;
      n_writes++;
      if (idx < TBL_N)
        quantile_mirror[idx] = sample;
      else
        n_dropped_writes++;
    end else begin
      item.rank = predict_rank(sample);
      n_lookups++;
    end
    pending_ranks.push_back(item);
  endtask

  // Sample the result mid-cycle, clear of the clock edge.
  always @(negedge clk) begin
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (pending_ranks.size() == 0) begin
        report_mismatch($sformatf("rank %0d strobed with no transfer waiting", out_rank));
      end else begin
        due = pending_ranks.pop_front();
        n_checked++;
        if (out_rank !== due.rank)
          report_mismatch($sformatf("transfer %0d: rank %0d, predicted %0d",
                                    due.seq, out_rank, due.rank));
      end
    end
  end

  // Reset table: zero, inside the first segment, on entries, past the end.
  task automatic test_reset_contents();
    issue_item(qtll_pkg::KIND_LOOKUP, qtll_pkg::INDEX_W'($urandom_range(127)), 32'd0);
    issue_item(qtll_pkg::KIND_LOOKUP, qtll_pkg::INDEX_W'($urandom_range(127)), 32'd1);
    issue_item(qtll_pkg::KIND_LOOKUP, qtll_pkg::INDEX_W'($urandom_range(127)),
               quantile_mirror[1]);
    issue_item(qtll_pkg::KIND_LOOKUP, qtll_pkg::INDEX_W'($urandom_range(127)), 32'd327680);
    issue_item(qtll_pkg::KIND_LOOKUP, qtll_pkg::INDEX_W'($urandom_range(127)),
               quantile_mirror[TBL_N-1]);
    issue_item(qtll_pkg::KIND_LOOKUP, qtll_pkg::INDEX_W'($urandom_range(127)),
               quantile_mirror[TBL_N-1] + 1);
    issue_item(qtll_pkg::KIND_LOOKUP, qtll_pkg::INDEX_W'($urandom_range(127)),
               32'hFFFF_FFFF);
  endtask

  // Full-scale last entry, an unsorted table and duplicate entries.
  task automatic test_edge_entries();
    issue_item(qtll_pkg::KIND_WRITE,  qtll_pkg::INDEX_W'(TBL_N-1), 32'hFFFF_FFFF);
    issue_item(qtll_pkg::KIND_LOOKUP, 7'd0, 32'hFFFF_FFFF);
    issue_item(qtll_pkg::KIND_LOOKUP, 7'd0, 32'hFFFF_FFFE);
    issue_item(qtll_pkg::KIND_WRITE,  7'd0, 32'h8000_0000);
    issue_item(qtll_pkg::KIND_LOOKUP, 7'd0, 32'h7FFF_FFFF);
    issue_item(qtll_pkg::KIND_LOOKUP, 7'd0, 32'h8000_0000);
    issue_item(qtll_pkg::KIND_LOOKUP, 7'd0, 32'h8000_0001);
    issue_item(qtll_pkg::KIND_WRITE,  7'd0, 32'd0);
    issue_item(qtll_pkg::KIND_WRITE,  7'd1, 32'd0);
    issue_item(qtll_pkg::KIND_LOOKUP, 7'd0, 32'd1);
    issue_item(qtll_pkg::KIND_LOOKUP, 7'd0, 32'd0);
  endtask

  // Writes past the table end must leave it untouched.
  task automatic test_index_range();
    issue_item(qtll_pkg::KIND_WRITE,  qtll_pkg::INDEX_W'(TBL_N), 32'd12345);
    issue_item(qtll_pkg::KIND_WRITE,  7'd127, 32'h0000_0001);
    issue_item(qtll_pkg::KIND_WRITE,  7'd64, quantile_mirror[64]);
    issue_item(qtll_pkg::KIND_LOOKUP, 7'd127, 32'd12345);
    issue_item(qtll_pkg::KIND_LOOKUP, 7'd100, 32'h0000_0001);
  endtask

  // Mostly lookups against sorted tables of varied span, plus stray writes.
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned n_items);
    int unsigned                   sent;
    int unsigned                   pick;
    int unsigned                   seg;
    logic [63:0]                   cursor;
    logic [63:0]                   step_max;
    logic [qtll_pkg::SAMPLE_W-1:0] v;
    logic [qtll_pkg::INDEX_W-1:0]  idx;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(299);
      if (sent == 0 || pick == 0) begin
        case ($urandom_range(3))
          0: begin
            cursor   = 64'($urandom_range(32'hFFFF));
            step_max = 64'd3;
          end
          1: begin
            cursor   = 64'($urandom_range(32'hFFFF));
            step_max = 64'hFFFF;
          end
          2: begin
            cursor   = 64'($urandom_range(255));
            step_max = 64'h0290_0000;
          end
          default: begin
            cursor   = 64'($urandom);
            step_max = (64'hFFFF_FFFF - cursor) / TBL_N;
          end
        endcase
        for (int i = 0; i < TBL_N; i++) begin
          issue_item(qtll_pkg::KIND_WRITE, qtll_pkg::INDEX_W'(i),
                     cursor[qtll_pkg::SAMPLE_W-1:0]);
          cursor += 64'($urandom_range(step_max[31:0]));
          if (cursor > 64'hFFFF_FFFF)
            cursor = 64'hFFFF_FFFF;
        end
        sent += TBL_N;
      end else if (pick < 30) begin
        if ($urandom_range(4) == 0)
          idx = qtll_pkg::INDEX_W'($urandom_range(127, TBL_N));
        else
          idx = qtll_pkg::INDEX_W'($urandom_range(TBL_N-1));
        // keep order with the neighbours half the time
        if (idx > 0 && idx < TBL_N-1 && $urandom_range(1) == 1)
          v = $urandom_range(quantile_mirror[idx+1], quantile_mirror[idx-1]);
        else
          v = $urandom;
        issue_item(qtll_pkg::KIND_WRITE, idx, v);
        sent++;
      end else begin
        case ($urandom_range(9))
          0: v = $urandom_range(quantile_mirror[0]);
          1: begin
            if (quantile_mirror[TBL_N-1] == '1)
              v = '1;
            else
              v = $urandom_range(32'hFFFF_FFFF, quantile_mirror[TBL_N-1] + 1);
          end
          2: v = quantile_mirror[$urandom_range(TBL_N-1)];
          8, 9: v = $urandom;
          default: begin
            seg = $urandom_range(TBL_N-1, 1);
            v   = $urandom_range(quantile_mirror[seg], quantile_mirror[seg-1]);
          end
        endcase
        issue_item(qtll_pkg::KIND_LOOKUP, qtll_pkg::INDEX_W'($urandom_range(127)), v);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_kind         = qtll_pkg::KIND_WRITE;
    in_entry_index  = '0;
    in_sample       = '0;
    sender_idle_pct = 27;
    for (int i = 0; i < TBL_N; i++)
      quantile_mirror[i] =
        qtll_pkg::SAMPLE_W'((64'(qtll_pkg::RESET_SPAN) * 64'(i)) / TBL_N);
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_contents();
    test_edge_entries();
    test_index_range();
    test_random_traffic(27, 700);
    test_random_traffic(71, 650);
    test_random_traffic(0, 650);

    start <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("transfers %0d: %0d lookups, %0d writes (%0d past the table end)",
             n_transfers, n_lookups, n_writes, n_dropped_writes);
    $display("ranks checked %0d, mismatches %0d", n_checked, n_mismatch);
    if (n_mismatch == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
